>>> src/ttbp_pkg.sv
package ttbp_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [3:0] HEX_TEN    = 4'hA;

   // register index of radix_mode (byte address 4*index)
   localparam logic CSR_IDX_RADIX = 1'b0;
   localparam logic RADIX_RESET   = 1'b1;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_EOL     = 2'd1,
      KIND_EOI     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_ZERO   = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] acc;
      logic [3:0] count;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{phase: PHASE_FIRST, acc: 8'h00, count: 4'h0};

   typedef struct packed {
      parse_type  next;
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } step_type;

endpackage

>>> src/ttbp_step.sv
module ttbp_step (
   input  logic                radix_mode,
   input  ttbp_pkg::parse_type state,
   input  ttbp_pkg::req_type   req,
   output ttbp_pkg::step_type  step
);

   function automatic logic is_hex_char(input logic [7:0] c);
      is_hex_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                    (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h61 + {4'h0, ttbp_pkg::HEX_TEN};
      end else begin
         d = c - 8'h41 + {4'h0, ttbp_pkg::HEX_TEN};
      end
      hex_value = d[3:0];
   endfunction

   logic [7:0]         c;
   logic               eoi;
   logic               is_bin;
   logic               is_blank;
   logic               is_hex;
   logic               is_x;
   logic [3:0]         hv;
   logic [7:0]         acc_shift;
   logic [3:0]         cnt_inc;
   ttbp_pkg::kind_type bad;
   ttbp_pkg::kind_type k0;
   logic [7:0]         v0;
   logic [1:0]         num;
   ttbp_pkg::parse_type nxt;
   logic [7:0]         acc_eff;
   logic               second_digit;

   assign c         = req.char_code;
   assign eoi       = req.end_of_input;
   assign is_bin    = (c == ttbp_pkg::CHAR_ZERO) || (c == ttbp_pkg::CHAR_ONE);
   assign is_blank  = (c == ttbp_pkg::CHAR_SPACE) || (c == ttbp_pkg::CHAR_TAB);
   assign is_hex    = is_hex_char(c);
   assign is_x      = (c == ttbp_pkg::CHAR_X_LO) || (c == ttbp_pkg::CHAR_X_UP);
   assign hv        = hex_value(c);
   assign acc_shift = {state.acc[6:0], c[0]};
   assign cnt_inc   = state.count + 4'd1;
   assign bad       = (c == ttbp_pkg::CHAR_NL) ? ttbp_pkg::KIND_EOL : ttbp_pkg::KIND_UNKNOWN;

   always_comb begin
      nxt          = state;
      num          = 2'd0;
      k0           = ttbp_pkg::KIND_DATA;
      v0           = 8'h00;
      acc_eff      = state.acc;
      second_digit = 1'b0;
      if (!radix_mode) begin
         priority if (eoi) begin
            k0  = ttbp_pkg::KIND_EOI;
            num = 2'd1;
            nxt = ttbp_pkg::PARSE_CLEAR;
         end else if (is_bin) begin
            nxt.acc   = acc_shift;
            nxt.count = cnt_inc;
            if (cnt_inc >= 4'(ttbp_pkg::BITS_PER_BYTE)) begin
               v0  = acc_shift;
               num = 2'd1;
               nxt = ttbp_pkg::PARSE_CLEAR;
            end
         end else if (is_blank) begin
            if (state.count != 4'd0) begin
               v0  = state.acc;
               num = 2'd1;
               nxt = ttbp_pkg::PARSE_CLEAR;
            end
         end else begin
            // partial byte goes out first, then the terminator's own result
            if (state.count != 4'd0) begin
               v0  = state.acc;
               num = 2'd2;
            end else begin
               k0  = bad;
               num = 2'd1;
            end
            nxt = ttbp_pkg::PARSE_CLEAR;
         end
      end else begin
         if (state.phase == ttbp_pkg::PHASE_ZERO) begin
            acc_eff      = 8'h00;
            second_digit = 1'b1;
         end else if (state.phase == ttbp_pkg::PHASE_SECOND) begin
            second_digit = 1'b1;
         end
         priority if (state.phase == ttbp_pkg::PHASE_ZERO && !eoi && is_x) begin
            // "0x" prefix: start over
            nxt.phase = ttbp_pkg::PHASE_FIRST;
            nxt.acc   = 8'h00;
         end else if (second_digit) begin
            if (!eoi && is_hex) begin
               v0 = {acc_eff[3:0], hv};
            end else begin
               k0 = eoi ? ttbp_pkg::KIND_EOI : bad;
            end
            num = 2'd1;
            nxt = ttbp_pkg::PARSE_CLEAR;
         end else if (!eoi && is_hex) begin
            nxt.acc   = {4'h0, hv};
            nxt.phase = (c == ttbp_pkg::CHAR_ZERO) ? ttbp_pkg::PHASE_ZERO
                                                    : ttbp_pkg::PHASE_SECOND;
         end else if (!eoi && is_blank) begin
            nxt = state;
         end else begin
            k0  = eoi ? ttbp_pkg::KIND_EOI : bad;
            num = 2'd1;
            nxt = ttbp_pkg::PARSE_CLEAR;
         end
      end
   end

   always_comb begin
      step              = '0;
      step.next         = nxt;
      step.num          = num;
      step.first.kind   = k0;
      step.first.value  = (k0 == ttbp_pkg::KIND_DATA) ? v0 : 8'h00;
      step.first.last   = (num == 2'd1);
      step.second.kind  = bad;
      step.second.value = 8'h00;
      step.second.last  = 1'b1;
   end

endmodule

>>> src/ttbp_rsp_buffer.sv
module ttbp_rsp_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [1:0]        load_num,
   input  ttbp_pkg::rsp_type load_first,
   input  ttbp_pkg::rsp_type load_second,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttbp_pkg::rsp_type rsp_payload
);

   logic [1:0]        count_ff, count_in;
   ttbp_pkg::rsp_type slot0_ff, slot0_in;
   ttbp_pkg::rsp_type slot1_ff, slot1_in;
   logic              pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot0_ff;
   assign can_load    = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff - {1'b0, pop};
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (load && load_num != 2'd0) begin
         count_in = load_num;
         slot0_in = load_first;
         slot1_in = load_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("first of a result pair marked last");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load && count_ff != 2'd0 |-> count_ff == 2'd1 && pop)
      else $error("load over a pending result");
`endif

endmodule

>>> src/text_to_byte_parser_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_payload (char_code, end_of_input)
// rsp       out        rsp_valid/rsp_ready    rsp_payload (kind, value, last)
// csr       in/out     psel/penable/pready    paddr, pwdata, prdata (radix_mode)
//
// One item per cycle while rsp_ready stays high; an item that gives two results
// holds the input stage while the two-entry result buffer drains.
// rsp_valid rises once the req item has passed the input register and then the
// result buffer; an rsp transfer can take place as soon as rsp_valid is high.
// Synchronous reset: radix_mode = hex, parse cleared, no clearing pass.
// A stalled rsp side backs up through the buffer into req_ready.
module text_to_byte_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttbp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttbp_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic                in_valid_ff, in_valid_in;
   ttbp_pkg::req_type   in_data_ff, in_data_in;
   logic                radix_ff, radix_in;
   ttbp_pkg::parse_type state_ff, state_in;
   ttbp_pkg::step_type  step;
   logic                can_load;
   logic                advance;
   logic                csr_write;
   logic                req_take;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == ttbp_pkg::CSR_IDX_RADIX);
   assign prdata    = (paddr[2] == ttbp_pkg::CSR_IDX_RADIX) ? {31'h0, radix_ff} : 32'h0;

   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   ttbp_step u_step (
      .radix_mode (radix_ff),
      .state      (state_ff),
      .req        (in_data_ff),
      .step       (step)
   );

   ttbp_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .load_num    (step.num),
      .load_first  (step.first),
      .load_second (step.second),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_data_in  = req_take ? req_payload : in_data_ff;
      radix_in    = radix_ff;
      state_in    = state_ff;
      if (csr_write) begin
         radix_in = pwdata[0];
         state_in = ttbp_pkg::PARSE_CLEAR;
      end else if (advance) begin
         state_in = step.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         radix_ff    <= ttbp_pkg::RADIX_RESET;
         state_ff    <= ttbp_pkg::PARSE_CLEAR;
      end else begin
         in_valid_ff <= in_valid_in;
         radix_ff    <= radix_in;
         state_ff    <= state_in;
      end
      in_data_ff <= in_data_in;
   end

`ifndef SYNTHESIS
   a_bin_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.count < 4'(ttbp_pkg::BITS_PER_BYTE))
      else $error("binary digit count reached a full byte without emitting");
   a_hex_no_count: assert property (@(posedge clock) disable iff (reset)
      radix_ff |-> state_ff.count == 4'd0)
      else $error("digit count set in hex mode");
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost an item");
`endif

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       RADIX_BIN     = 1'b0;
   localparam logic       RADIX_HEX     = 1'b1;
   localparam logic [2:0] RADIX_ADDR    = {ttbp_pkg::CSR_IDX_RADIX, 2'b00};
   localparam logic [2:0] SPARE_ADDR    = {~ttbp_pkg::CSR_IDX_RADIX, 2'b00};
   localparam int         SETTLE_CYCLES = 6;
   localparam int         DRAIN_LIMIT   = 2000;
   localparam int         NUM_PHASES    = 6;
   localparam int         PHASE_CHARS   = 120;
   localparam int         MAX_REPORTS   = 10;
   localparam int         NO_TYPED      = -1;
   localparam int         RUN_LIMIT_NS  = 200_000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   ttbp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   ttbp_pkg::rsp_type rsp_payload;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [2:0]        paddr       = '0;
   logic [31:0]       pwdata      = '0;
   logic [31:0]       prdata;
   logic              pready;

   text_to_byte_parser_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #1 clock = ~clock;

   // parser shadow state
   logic              pred_radix;
   logic [1:0]        pred_phase;
   logic [7:0]        pred_acc;
   logic [3:0]        pred_count;
   ttbp_pkg::rsp_type step_rsp [2];
   int                step_num;

   ttbp_pkg::rsp_type pending_results [$];
   logic              quiet        = 1'b0;
   int                fail_count   = 0;
   int                chars_sent   = 0;
   int                results_seen = 0;
   int                csr_writes   = 0;

   typedef struct {
      logic              set_radix;
      logic [7:0]        ch;
      logic              eoi;
      int                num_typed;
      ttbp_pkg::rsp_type typed0;
      ttbp_pkg::rsp_type typed1;
   } row_type;

   row_type directed_rows [$];

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == ttbp_pkg::CHAR_SPACE || c == ttbp_pkg::CHAR_TAB;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_nibble(logic [7:0] c);
      if (c <= "9") return 4'(c - "0");
      if (c >= "a") return 4'(c - "a") + ttbp_pkg::HEX_TEN;
      return 4'(c - "A") + ttbp_pkg::HEX_TEN;
   endfunction

   function automatic ttbp_pkg::kind_type bad_kind(logic eoi, logic [7:0] c);
      if (eoi) return ttbp_pkg::KIND_EOI;
      if (c == ttbp_pkg::CHAR_NL) return ttbp_pkg::KIND_EOL;
      return ttbp_pkg::KIND_UNKNOWN;
   endfunction

   function automatic void clear_parse();
      pred_phase = ttbp_pkg::PHASE_FIRST;
      pred_acc   = 8'h00;
      pred_count = 4'h0;
   endfunction

   function automatic void add_result(ttbp_pkg::kind_type k, logic [7:0] v);
      step_rsp[step_num] = '{kind: k, value: (k == ttbp_pkg::KIND_DATA) ? v : 8'h00,
                             last: 1'b0};
      step_num++;
   endfunction

   // Advances the shadow parser by one character, leaves the results in step_rsp.
   function automatic void parse_char(logic [7:0] c, logic eoi);
      logic [1:0] ph;
      logic [7:0] byte_val;
      step_num = 0;
      if (pred_radix == RADIX_BIN) begin
         if (eoi) begin
            add_result(ttbp_pkg::KIND_EOI, 8'h00);
            clear_parse();
         end else if (c == ttbp_pkg::CHAR_ZERO || c == ttbp_pkg::CHAR_ONE) begin
            pred_acc   = {pred_acc[6:0], c[0]};
            pred_count = pred_count + 4'd1;
            if (pred_count >= ttbp_pkg::BITS_PER_BYTE) begin
               add_result(ttbp_pkg::KIND_DATA, pred_acc);
               clear_parse();
            end
         end else if (is_blank(c)) begin
            if (pred_count != 0) begin
               add_result(ttbp_pkg::KIND_DATA, pred_acc);
               clear_parse();
            end
         end else begin
            // partial byte flushed first, then the character itself
            if (pred_count != 0) add_result(ttbp_pkg::KIND_DATA, pred_acc);
            add_result(bad_kind(1'b0, c), 8'h00);
            clear_parse();
         end
      end else begin
         ph = pred_phase;
         if (ph == ttbp_pkg::PHASE_ZERO) begin
            if (!eoi && (c == ttbp_pkg::CHAR_X_LO || c == ttbp_pkg::CHAR_X_UP)) begin
               pred_phase = ttbp_pkg::PHASE_FIRST;
               pred_acc   = 8'h00;
               return;
            end
            pred_acc = 8'h00;
            ph       = ttbp_pkg::PHASE_SECOND;
         end
         if (ph == ttbp_pkg::PHASE_SECOND) begin
            if (!eoi && is_hex(c)) begin
               byte_val = (pred_acc << 4) + {4'h0, hex_nibble(c)};
               add_result(ttbp_pkg::KIND_DATA, byte_val);
            end else begin
               add_result(bad_kind(eoi, c), 8'h00);
            end
            clear_parse();
         end else if (!eoi && is_hex(c)) begin
            pred_acc   = {4'h0, hex_nibble(c)};
            pred_phase = (c == ttbp_pkg::CHAR_ZERO) ? ttbp_pkg::PHASE_ZERO
                                                     : ttbp_pkg::PHASE_SECOND;
         end else if (!eoi && is_blank(c)) begin
            // leading blank, nothing to do
         end else begin
            add_result(bad_kind(eoi, c), 8'h00);
            clear_parse();
         end
      end
      if (step_num > 0) step_rsp[step_num - 1].last = 1'b1;
   endfunction

   function automatic void add_row(logic [7:0] ch, logic eoi = 1'b0,
                                   int num_typed = NO_TYPED,
                                   ttbp_pkg::kind_type k0 = ttbp_pkg::KIND_DATA,
                                   logic [7:0] v0 = 8'h00,
                                   ttbp_pkg::kind_type k1 = ttbp_pkg::KIND_DATA,
                                   logic [7:0] v1 = 8'h00);
      row_type r;
      r.set_radix = 1'b0;
      r.ch        = ch;
      r.eoi       = eoi;
      r.num_typed = num_typed;
      r.typed0    = '{kind: k0, value: v0, last: num_typed == 1};
      r.typed1    = '{kind: k1, value: v1, last: 1'b1};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_radix_row(logic mode);
      row_type r;
      r           = '{default: '0};
      r.set_radix = 1'b1;
      r.ch        = {7'h00, mode};
      r.num_typed = 0;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [7:0] blank_char();
      return $urandom_range(0, 1) ? ttbp_pkg::CHAR_SPACE : ttbp_pkg::CHAR_TAB;
   endfunction

   function automatic logic [7:0] hex_char();
      int n;
      n = $urandom_range(0, 21);
      if (n < 10) return 8'("0" + n);
      if (n < 16) return 8'("a" + n - 10);
      return 8'("A" + n - 16);
   endfunction

   function automatic logic [7:0] noise_char();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic transfer_char(input logic [7:0] c, input logic eoi,
                                input int num_typed = NO_TYPED,
                                input ttbp_pkg::rsp_type typed0 = '0,
                                input ttbp_pkg::rsp_type typed1 = '0);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{char_code: c, end_of_input: eoi};
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      parse_char(c, eoi);
      if (num_typed == NO_TYPED) begin
         for (int k = 0; k < step_num; k++) pending_results.push_back(step_rsp[k]);
      end else begin
         if (num_typed > 0) pending_results.push_back(typed0);
         if (num_typed > 1) pending_results.push_back(typed1);
      end
   endtask

   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // characters that give no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_csr(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] rdata;
      drain_results();
      csr_access(1'b1, addr, data, rdata);
      csr_writes++;
      if (addr == RADIX_ADDR) begin
         pred_radix = data[0];
         clear_parse();
      end
      // the bus goes idle between the write and the readback
      @(posedge clock);
      csr_access(1'b0, RADIX_ADDR, 32'h0, rdata);
      if (rdata[0] !== pred_radix)
         note_failure($sformatf("radix readback: expected %0b, got %0b", pred_radix, rdata[0]));
   endtask

   task automatic hex_token();
      int pick;
      repeat ($urandom_range(0, 2)) transfer_char(blank_char(), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         transfer_char(ttbp_pkg::CHAR_ZERO, 1'b0);
         transfer_char($urandom_range(0, 1) ? ttbp_pkg::CHAR_X_LO : ttbp_pkg::CHAR_X_UP, 1'b0);
      end
      transfer_char(hex_char(), 1'b0);
      pick = $urandom_range(0, 15);
      if (pick == 0) transfer_char(blank_char(), 1'b0);
      else if (pick == 1) transfer_char(noise_char(), 1'b0);
      else if (pick == 2) transfer_char(noise_char(), 1'b1);
      else transfer_char(hex_char(), 1'b0);
      pick = $urandom_range(0, 11);
      if (pick == 0) transfer_char(ttbp_pkg::CHAR_NL, 1'b0);
      else if (pick == 1) transfer_char(noise_char(), 1'b0);
      else if (pick == 2) transfer_char(noise_char(), 1'b1);
   endtask

   task automatic bin_token();
      int pick;
      repeat ($urandom_range(1, 8))
         transfer_char($urandom_range(0, 1) ? ttbp_pkg::CHAR_ONE : ttbp_pkg::CHAR_ZERO, 1'b0);
      pick = $urandom_range(0, 9);
      if (pick < 5) transfer_char(blank_char(), 1'b0);
      else if (pick == 5) transfer_char(ttbp_pkg::CHAR_NL, 1'b0);
      else if (pick == 6) transfer_char(noise_char(), 1'b0);
      else if (pick == 7) transfer_char(noise_char(), 1'b1);
      // otherwise digits run on into the next token
   endtask

   always @(posedge clock) begin
      ttbp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result kind=%0d value=%02h last=%0b",
                                   rsp_payload.kind, rsp_payload.value, rsp_payload.last));
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.kind !== want.kind || rsp_payload.value !== want.value ||
                rsp_payload.last !== want.last)
               note_failure($sformatf(
                  {"result mismatch: expected kind=%0d value=%02h last=%0b, ",
                   "got kind=%0d value=%02h last=%0b"},
                  want.kind, want.value, want.last,
                  rsp_payload.kind, rsp_payload.value, rsp_payload.last));
         end
      end
   end

   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS * 1ns);
      $display("text_to_byte_parser_core verification failed");
      $finish;
   end

   initial begin : stimulus
      row_type row;
      logic    mode;
      int      phase_end;

      pred_radix = ttbp_pkg::RADIX_RESET;
      clear_parse();

      // hex mode out of reset
      add_row("0"); add_row("x"); add_row("a"); add_row("5");
      add_row("0"); add_row("0", 1'b0, 1, ttbp_pkg::KIND_DATA, 8'h00);
      add_row("0"); add_row(ttbp_pkg::CHAR_NL, 1'b0, 1, ttbp_pkg::KIND_EOL);
      // blank after first digit
      add_row("F"); add_row(ttbp_pkg::CHAR_SPACE, 1'b0, 1, ttbp_pkg::KIND_UNKNOWN);
      add_row(8'hFF, 1'b0, 1, ttbp_pkg::KIND_UNKNOWN);
      add_row(ttbp_pkg::CHAR_TAB, 1'b0, 0);                       // leading blank skipped
      add_row("7"); add_row(8'hFF, 1'b1, 1, ttbp_pkg::KIND_EOI);  // partial byte dropped
      add_radix_row(RADIX_BIN);
      repeat (7) add_row(ttbp_pkg::CHAR_ONE);
      // eighth digit emits
      add_row(ttbp_pkg::CHAR_ONE, 1'b0, 1, ttbp_pkg::KIND_DATA, 8'hFF);
      add_row(ttbp_pkg::CHAR_ONE);
      add_row(ttbp_pkg::CHAR_TAB, 1'b0, 1, ttbp_pkg::KIND_DATA, 8'h01);
      add_row(ttbp_pkg::CHAR_ONE); add_row(ttbp_pkg::CHAR_ZERO);
      // flush, then end of line
      add_row(ttbp_pkg::CHAR_NL, 1'b0, 2, ttbp_pkg::KIND_DATA, 8'h02, ttbp_pkg::KIND_EOL);
      add_row(ttbp_pkg::CHAR_ZERO);
      add_row(ttbp_pkg::CHAR_ZERO, 1'b1, 1, ttbp_pkg::KIND_EOI);
      add_row(8'h00, 1'b0, 1, ttbp_pkg::KIND_UNKNOWN);
      add_row(8'h7F);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.set_radix) set_csr(RADIX_ADDR, {31'($urandom()), row.ch[0]});
         else transfer_char(row.ch, row.eoi, row.num_typed, row.typed0, row.typed1);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         mode = p[0] ? RADIX_BIN : RADIX_HEX;
         if (p == 2) set_csr(SPARE_ADDR, $urandom());
         set_csr(RADIX_ADDR, {31'($urandom()), mode});
         quiet     = (p == 3);
         phase_end = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               transfer_char(noise_char(), $urandom_range(0, 7) == 0);
            else if (mode == RADIX_HEX)
               hex_token();
            else
               bin_token();
         end
      end
      quiet = 1'b0;

      drain_results();
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", pending_results.size()));

      $display("Sent %0d characters in hex and binary text, checked %0d parsed results,",
               chars_sent, results_seen);
      $display("with %0d register writes between phases and %0d failures.",
               csr_writes, fail_count);
      if (fail_count == 0) begin
         $display("text_to_byte_parser_core verification clean");
      end else begin
         $display("text_to_byte_parser_core verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ttbp_pkg.sv
src/ttbp_step.sv
src/ttbp_rsp_buffer.sv
src/text_to_byte_parser_core.sv
sim/tb_top.sv
